/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared constants and types for the text terminal cell writer
// Grid geometry, character codes, stream word widths and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int NUM_COLS = 100;
  localparam int NUM_ROWS = 37;
  localparam int CELLS    = NUM_COLS * NUM_ROWS;
  localparam int ADDR_W   = $clog2(CELLS);

  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int CHAR_W = 7;
  localparam int CODE_W = 8;

  localparam int IN_W  = 24;
  localparam int OUT_W = 24;

  localparam logic [CODE_W-1:0] CH_NEWLINE     = 8'd10;
  localparam logic [CODE_W-1:0] CH_RETURN      = 8'd13;
  localparam logic [CODE_W-1:0] CH_BACKSPACE   = 8'd8;
  localparam logic [CODE_W-1:0] CH_SPACE       = 8'd32;
  localparam logic [CODE_W-1:0] CH_FIRST_PRINT = 8'd32;
  localparam logic [CODE_W-1:0] CH_LAST_PRINT  = 8'd126;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic load;
    logic decode;
    logic clr_step;
    logic row_step;
    logic addr_step;
    logic access;
    logic resp_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic scroll;
    logic clr_done;
    logic out_full;
  } tcw_sts_t;

endpackage

/* src/tcw_cell_ram.sv */
// ----------------------------------------------------------------------------
// tcw_cell_ram: character cell store
// Single-port memory of NUM_ROWS x NUM_COLS cells with registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [tcw_pkg::ADDR_W-1:0]   addr,
  input  logic [tcw_pkg::CHAR_W-1:0]   wdata,
  output logic [tcw_pkg::CHAR_W-1:0]   rdata
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] mem [CELLS];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencing controller
// Walks each word through decode, row clearing when it scrolls, address build, cell access
// and response; runs the full clearing pass after reset.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_SCROLL = 8'b0000_1000,
    S_ROW    = 8'b0001_0000,
    S_ADDR   = 8'b0010_0000,
    S_ACCESS = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } tcw_state_t;

  tcw_state_t state_r, state_nxt;
  logic       out_free;

  assign out_free  = !sts.out_full || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = sts.scroll ? S_SCROLL : S_ROW;
      end
      S_SCROLL: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.row_step = 1'b1;
        state_nxt    = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_step = 1'b1;
        state_nxt     = S_ACCESS;
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/tcw_dp.sv */
// ----------------------------------------------------------------------------
// tcw_dp: cursor, ring pointer and cell access datapath
// Holds the cursor and top-row pointer, builds cell addresses, clears rows
// and owns the cell store and the result register.
// ----------------------------------------------------------------------------
module tcw_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcw_pkg::tcw_cmd_t           cmd,
  output tcw_pkg::tcw_sts_t           sts,
  input  logic                        in_tuser,
  input  logic [tcw_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tcw_pkg::OUT_W-1:0]   out_tdata
);
  import tcw_pkg::*;

  logic              act_r;
  logic [CODE_W-1:0] code_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  rcol_r;

  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_line_r;
  logic [ROW_W-1:0]  top_r;

  logic              scrolled_r;
  logic [ROW_W-1:0]  tgt_row_r;
  logic [COL_W-1:0]  tgt_col_r;
  logic              oob_r;
  logic              we_r;
  logic [CHAR_W-1:0] wchar_r;

  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_last_r;
  logic [ROW_W-1:0]  phys_r;
  logic [ADDR_W-1:0] addr_r;

  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic              is_put, is_nl, is_cr, is_bs, is_pr;
  logic              wrap, col_nz, at_bottom, line_adv, dec_scroll, do_write;
  logic [COL_W-1:0]  col_dec, wcol, col_nxt;
  logic [ROW_W-1:0]  line_nxt, top_inc;
  logic [ADDR_W-1:0] clr_base;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys;
  logic [CHAR_W-1:0] rd_char;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  assign is_put    = (act_r == ACT_PUT);
  assign is_nl     = (code_r == CH_NEWLINE);
  assign is_cr     = (code_r == CH_RETURN);
  assign is_bs     = (code_r == CH_BACKSPACE);
  assign is_pr     = (code_r >= CH_FIRST_PRINT) && (code_r <= CH_LAST_PRINT);
  assign wrap      = (cur_col_r >= COL_W'(NUM_COLS));
  assign col_nz    = (cur_col_r != '0);
  assign col_dec   = cur_col_r - COL_W'(1);
  assign at_bottom = (cur_line_r == ROW_W'(NUM_ROWS - 1));
  assign line_adv  = is_put && (is_nl || (is_pr && wrap));
  assign dec_scroll = line_adv && at_bottom;
  assign line_nxt  = (line_adv && !at_bottom) ? cur_line_r + ROW_W'(1) : cur_line_r;
  assign top_inc   = (top_r == ROW_W'(NUM_ROWS - 1)) ? '0 : top_r + ROW_W'(1);
  assign wcol      = is_bs ? col_dec : (wrap ? '0 : cur_col_r);
  assign do_write  = is_put && ((is_bs && col_nz) || is_pr);
  assign clr_base  = ADDR_W'(top_r) * ADDR_W'(NUM_COLS);

  always_comb begin
    priority if (!is_put) begin
      col_nxt = cur_col_r;
    end else if (is_nl || is_cr) begin
      col_nxt = '0;
    end else if (is_bs) begin
      col_nxt = col_nz ? col_dec : cur_col_r;
    end else if (is_pr) begin
      col_nxt = wcol + COL_W'(1);
    end else begin
      col_nxt = cur_col_r;
    end
  end

  assign row_sum = {1'b0, top_r} + {1'b0, tgt_row_r};
  assign phys    = (row_sum >= (ROW_W+1)'(NUM_ROWS)) ?
                   ROW_W'(row_sum - (ROW_W+1)'(NUM_ROWS)) : ROW_W'(row_sum);

  assign sts.scroll   = dec_scroll;
  assign sts.clr_done = (clr_addr_r == clr_last_r);
  assign sts.out_full = out_tvalid_r;

  assign ram_we    = cmd.clr_step || (cmd.access && we_r);
  assign ram_re    = cmd.access && (act_r == ACT_READ) && !oob_r;
  assign ram_addr  = cmd.clr_step ? clr_addr_r : addr_r;
  assign ram_wdata = cmd.clr_step ? '0 : wchar_r;

  tcw_cell_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_char = ((act_r == ACT_READ) && !oob_r) ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r    <= '0;
      cur_line_r   <= '0;
      top_r        <= '0;
      clr_addr_r   <= '0;
      clr_last_r   <= ADDR_W'(CELLS - 1);
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.decode) begin
        cur_col_r  <= col_nxt;
        cur_line_r <= line_nxt;
        if (dec_scroll) begin
          top_r      <= top_inc;
          clr_addr_r <= clr_base;
          clr_last_r <= clr_base + ADDR_W'(NUM_COLS - 1);
        end
      end else if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (cmd.resp_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_tuser;
      code_r <= in_tdata[CODE_W-1:0];
      rrow_r <= in_tdata[CODE_W +: ROW_W];
      rcol_r <= in_tdata[CODE_W+ROW_W +: COL_W];
    end
    if (cmd.decode) begin
      scrolled_r <= dec_scroll;
      tgt_row_r  <= is_put ? line_nxt : rrow_r;
      tgt_col_r  <= is_put ? wcol : rcol_r;
      oob_r      <= (rrow_r >= ROW_W'(NUM_ROWS)) || (rcol_r >= COL_W'(NUM_COLS));
      we_r       <= do_write;
      wchar_r    <= is_bs ? CH_SPACE[CHAR_W-1:0] : code_r[CHAR_W-1:0];
    end
    if (cmd.row_step) begin
      phys_r <= phys;
    end
    if (cmd.addr_step) begin
      addr_r <= ADDR_W'(phys_r) * ADDR_W'(NUM_COLS) + ADDR_W'(tgt_col_r);
    end
    if (cmd.resp_load) begin
      out_data_r <= OUT_W'({scrolled_r, cur_line_r, cur_col_r, rd_char});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

/* src/text_terminal_cell_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_terminal_cell_writer_unit: text-mode character cell writer
// Places bytes in a 37 x 100 character grid with a cursor and returns cells
// for display.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser selects put (0) or cell read (1); in_tdata carries
//   the byte, read row and read column. Every input word yields exactly one
//   output word with the read cell (0 for puts), the cursor after the step
//   and a flag that the screen scrolled.
//   Flow: one word is in work at a time, passing through the shared address
//   path and single-port cell store. A step that scrolls also clears the new
//   bottom row (NUM_COLS cells) through that port.
//   Reset: the cell store is cleared by a pass over all NUM_ROWS * NUM_COLS
//   (3700) cells; in_tready stays low until it ends.
//   Stall: the result sits in the output register while out_tready is low;
//   the next input word is still taken and worked up to its result, which
//   waits until the register frees.
// ----------------------------------------------------------------------------
module text_terminal_cell_writer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_tuser,   // action
  input  logic [tcw_pkg::IN_W-1:0]   in_tdata,   // char_code, read_row, read_col
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tcw_pkg::OUT_W-1:0]  out_tdata   // cell_char, cursor_col, cursor_row, scrolled
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tcw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in work");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[CHAR_W+COL_W +: ROW_W] < ROW_W'(NUM_ROWS)) &&
                   (out_tdata[CHAR_W +: COL_W] <= COL_W'(NUM_COLS)))
    else $error("cursor out of range");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[CHAR_W+COL_W+ROW_W] |->
      out_tdata[CHAR_W+COL_W +: ROW_W] == ROW_W'(NUM_ROWS - 1))
    else $error("scroll reported away from the bottom row");

endmodule
